/* hdl/ihex_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and codes of the Intel HEX record decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_COLON = 3'd1;
    localparam logic [2:0] ERR_SHORT    = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM = 3'd4;

    localparam logic RESULT_DATA   = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_CKSUM  = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic        record_valid;
        logic [2:0]  error_code;
        logic [7:0]  rec_len;
        logic [19:0] record_address;
        logic [7:0]  rec_type;
        logic [7:0]  record_checksum;
    } t_result;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] level;
    } t_queue_status;

endpackage
`default_nettype wire

/* hdl/ihex_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_parser
// Input register, per-line state and the decode of one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module ihex_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire  [7:0]           i_character,
    input  wire                  i_line_end,
    output logic                 o_stall,
    input  wire                  i_room,
    input  wire  [15:0]          i_offset,
    input  wire                  i_cksum_en,
    output logic                 o_push,
    output ihex_pkg::t_result    o_result
);
    import ihex_pkg::*;

    localparam logic [7:0] POS_MAX = 8'd255;

    // 5-bit value, bit 4 set for a character that is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= "0" && c <= "9") v = {1'b0, 4'(c - "0")};
        else if (c >= "A" && c <= "F") v = {1'b0, 4'(c - "A" + 8'd10)};
        else if (c >= "a" && c <= "f") v = {1'b0, 4'(c - "a" + 8'd10)};
        return v;
    endfunction

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    logic [7:0]  r_pos,   n_pos;
    logic [3:0]  r_high,  n_high;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_addr,  n_addr;
    logic [7:0]  r_type,  n_type;
    logic [7:0]  r_sum,   n_sum;
    logic [7:0]  r_cksum, n_cksum;
    logic        r_colon, n_colon;
    logic        r_bad,   n_bad;

    logic        proc;
    logic        have_data;
    logic [7:0]  data_val;
    logic [7:0]  data_idx;
    logic [4:0]  hv;
    logic [3:0]  nib;
    logic [7:0]  b;
    logic [6:0]  k;
    logic [8:0]  data_lim;
    logic [9:0]  need_len;
    logic [2:0]  err;

    assign proc    = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;

    always_comb begin
        n_pos     = r_pos;
        n_high    = r_high;
        n_count   = r_count;
        n_addr    = r_addr;
        n_type    = r_type;
        n_sum     = r_sum;
        n_cksum   = r_cksum;
        n_colon   = r_colon;
        n_bad     = r_bad;
        have_data = 1'b0;
        data_val  = 8'd0;
        data_idx  = 8'd0;
        hv        = hex_value(r_in_char);
        nib       = hv[4] ? 4'd0 : hv[3:0];
        b         = {r_high, nib};
        k         = r_pos[7:1] - 7'd1;
        data_lim  = 9'd4 + {1'b0, r_count};

        if (r_pos == 8'd0) begin
            n_colon = (r_in_char == ":");
        end else begin
            if (hv[4]) n_bad = 1'b1;
            if (r_pos != POS_MAX) begin
                if (r_pos[0]) begin
                    n_high = nib;
                end else begin
                    priority if (k == 7'd0) begin
                        n_count = b;
                        n_sum   = r_sum + b;
                    end else if (k == 7'd1) begin
                        n_addr[15:8] = b;
                        n_sum        = r_sum + b;
                    end else if (k == 7'd2) begin
                        n_addr[7:0] = b;
                        n_sum       = r_sum + b;
                    end else if (k == 7'd3) begin
                        n_type = b;
                        n_sum  = r_sum + b;
                    end else if ({2'b0, k} < data_lim) begin
                        n_sum = r_sum + b;
                        if (r_colon && !n_bad) begin
                            have_data = 1'b1;
                            data_val  = b;
                            data_idx  = {1'b0, k - 7'd4};
                        end
                    end else if ({2'b0, k} == data_lim) begin
                        n_cksum = b;
                    end else begin
                        // past the checksum only the digit check applies
                        n_cksum = r_cksum;
                    end
                end
            end
        end
        if (r_pos != POS_MAX) n_pos = r_pos + 8'd1;

        need_len = {1'b0, n_count, 1'b0} + 10'd11;
        priority if (!n_colon) err = ERR_NO_COLON;
        else if ({2'b0, n_pos} < need_len) err = ERR_SHORT;
        else if (n_bad) err = ERR_BAD_HEX;
        else if (i_cksum_en && (8'd0 - n_sum) != n_cksum) err = ERR_CHECKSUM;
        else err = ERR_NONE;
    end

    always_comb begin
        o_result.rec_len         = n_count;
        o_result.record_address  = {4'd0, n_addr} | {i_offset, 4'd0};
        o_result.rec_type        = n_type;
        o_result.record_checksum = n_cksum;
        if (r_in_last) begin
            o_result.result_kind  = RESULT_STATUS;
            o_result.data_byte    = 8'd0;
            o_result.byte_index   = 8'd0;
            o_result.record_valid = (err == ERR_NONE);
            o_result.error_code   = err;
        end else begin
            o_result.result_kind  = RESULT_DATA;
            o_result.data_byte    = data_val;
            o_result.byte_index   = data_idx;
            o_result.record_valid = 1'b0;
            o_result.error_code   = ERR_NONE;
        end
    end

    assign o_push = proc && (r_in_last || have_data);

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_character;
            r_in_last <= i_line_end;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_in_last)) begin
            r_pos   <= 8'd0;
            r_high  <= 4'd0;
            r_count <= 8'd0;
            r_addr  <= 16'd0;
            r_type  <= 8'd0;
            r_sum   <= 8'd0;
            r_cksum <= 8'd0;
            r_colon <= 1'b0;
            r_bad   <= 1'b0;
        end else if (proc) begin
            r_pos   <= n_pos;
            r_high  <= n_high;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_type  <= n_type;
            r_sum   <= n_sum;
            r_cksum <= n_cksum;
            r_colon <= n_colon;
            r_bad   <= n_bad;
        end
    end

endmodule
`default_nettype wire

/* hdl/ihex_out_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_out_queue
// Two-entry result register so decoding continues while a result waits.
// ----------------------------------------------------------------------------
module ihex_out_queue (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  ihex_pkg::t_result        i_result,
    output logic                     o_room,
    output logic                     o_valid,
    input  wire                      i_stall,
    output ihex_pkg::t_result        o_result,
    output ihex_pkg::t_queue_status  o_status
);
    import ihex_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid  = (r_count != 2'd0);
    assign pop      = o_valid && !i_stall;
    assign o_room   = (r_count != 2'd2) || pop;
    assign o_result = r_mem[r_rd_ptr];

    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.level = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_result;
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (pop) r_rd_ptr <= !r_rd_ptr;
            if (i_push && !pop) r_count <= r_count + 2'd1;
            else if (pop && !i_push) r_count <= r_count - 2'd1;
        end
    end

endmodule
`default_nettype wire

/* hdl/intel_hex_record_decoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// intel_hex_record_decoder_core
// Decodes Intel HEX lines one character per cycle, unless stalled, into data
// byte requests and one status request per line, with an APB register port.
// ----------------------------------------------------------------------------
// An accepted character passes the input register and then the result queue
//   before its result can be taken.
// throughput: 1 character per cycle unless stalled, set by the single decode
//   stage that merges a nibble and adds one byte into the line sum
// reset (synchronous, active low): line state cleared, address_offset 0,
//   checksum_enable 1, input and result registers empty
module intel_hex_record_decoder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_character,
    input  wire         i_line_end,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_index,
    output logic        o_record_valid,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_rec_len,
    output logic [19:0] o_record_address,
    output logic [7:0]  o_rec_type,
    output logic [7:0]  o_record_checksum,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ihex_pkg::*;

    logic [15:0]   r_offset;
    logic          r_cksum_en;
    logic          wr_en;
    logic          room;
    logic          push;
    t_result       dec_result;
    t_result       out_result;
    t_queue_status q_status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= 16'd0;
            r_cksum_en <= 1'b1;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_OFFSET: r_offset   <= pwdata[15:0];
                REG_CKSUM:  r_cksum_en <= pwdata[0];
                default:    r_offset   <= r_offset;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OFFSET: prdata = {16'd0, r_offset};
            REG_CKSUM:  prdata = {31'd0, r_cksum_en};
            default:    prdata = 32'd0;
        endcase
    end

    ihex_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_character (i_character),
        .i_line_end  (i_line_end),
        .o_stall     (o_stall),
        .i_room      (room),
        .i_offset    (r_offset),
        .i_cksum_en  (r_cksum_en),
        .o_push      (push),
        .o_result    (dec_result)
    );

    ihex_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (dec_result),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result),
        .o_status (q_status)
    );

    assign o_result_kind     = out_result.result_kind;
    assign o_data_byte       = out_result.data_byte;
    assign o_byte_index      = out_result.byte_index;
    assign o_record_valid    = out_result.record_valid;
    assign o_error_code      = out_result.error_code;
    assign o_rec_len         = out_result.rec_len;
    assign o_record_address  = out_result.record_address;
    assign o_rec_type        = out_result.rec_type;
    assign o_record_checksum = out_result.record_checksum;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level != 2'd3)
        else $error("result queue level out of range");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && q_status.full |-> !i_stall)
        else $error("request pushed into a full result queue");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == RESULT_STATUS |->
            o_record_valid == (o_error_code == ERR_NONE) &&
            o_data_byte == 8'd0 && o_byte_index == 8'd0)
        else $error("inconsistent status request");

    a_data_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == RESULT_DATA |->
            !o_record_valid && o_error_code == ERR_NONE)
        else $error("data request carries status fields");

    a_valid_tracks_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == !q_status.empty)
        else $error("output valid disagrees with queue level");

endmodule
`default_nettype wire
